// File: hdl/clsf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the content-length framer.
// No dependencies; imported by the register, core, top-level and test files.
package clsf_pkg;

    localparam int HDR_W  = 16;
    localparam int BODY_W = 22;
    localparam int ACC_W  = 23;

    localparam logic [HDR_W-1:0]  MAX_HEADER_RESET = 16'd32768;
    localparam logic [BODY_W-1:0] MAX_BODY_RESET   = 22'd2097152;
    localparam logic [ACC_W-1:0]  ACCUM_MAX        = 23'h7F_FFFF;
    localparam logic [HDR_W-1:0]  COUNT_MAX        = 16'hFFFF;
    localparam logic [3:0]        KEY_LEN          = 4'd14;

    // Register indexes (word address bit 2)
    localparam logic REG_MAX_HEADER = 1'b0;
    localparam logic REG_MAX_BODY   = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_HDR_LONG   = 2'd1;
    localparam logic [1:0] ST_BAD_LENGTH = 2'd2;
    localparam logic [1:0] ST_BODY_LONG  = 2'd3;

    // Line scanner states
    localparam logic [2:0] LF_KEY_LEAD  = 3'd0;
    localparam logic [2:0] LF_KEY       = 3'd1;
    localparam logic [2:0] LF_KEY_TRAIL = 3'd2;
    localparam logic [2:0] LF_VAL_LEAD  = 3'd3;
    localparam logic [2:0] LF_SIGN      = 3'd4;
    localparam logic [2:0] LF_DIGITS    = 3'd5;
    localparam logic [2:0] LF_SKIP      = 3'd6;

    // Terminator match progress
    localparam logic [1:0] TM_NONE = 2'd0;
    localparam logic [1:0] TM_CR   = 2'd1;
    localparam logic [1:0] TM_CRLF = 2'd2;
    localparam logic [1:0] TM_CR2  = 2'd3;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    typedef struct packed {
        logic [HDR_W-1:0]  max_header_bytes;
        logic [BODY_W-1:0] max_body_bytes;
    } clsf_cfg_t;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic              in_body;
        logic              hdr_done;
        logic              frame_end;
        logic [BODY_W-1:0] body_length;
        logic [1:0]        status;
    } clsf_result_t;

    // Lower-case key text, one character per position
    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "c";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "l";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'h20) : c;
    endfunction

    // acc * 10 + d, saturating
    function automatic logic [ACC_W-1:0] add_digit(input logic [ACC_W-1:0] acc,
                                                   input logic [3:0] d);
        logic [ACC_W+3:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{ACC_W{1'b0}}, d};
        return (v > {4'b0000, ACCUM_MAX}) ? ACCUM_MAX : v[ACC_W-1:0];
    endfunction

endpackage

// File: hdl/clsf_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the framer's byte input and result output.
// Depends on nothing but the widths of the work fields.
interface clsf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       new_stream;

    modport source (output valid, output data_byte, output new_stream, input ready);
    modport sink (input valid, input data_byte, input new_stream, output ready);
endinterface

interface clsf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        in_body;
    logic        hdr_done;
    logic        frame_end;
    logic [21:0] body_length;
    logic [1:0]  status;

    modport source (output valid, output out_byte, output in_body, output hdr_done,
                    output frame_end, output body_length, output status, input ready);
    modport sink (input valid, input out_byte, input in_body, input hdr_done,
                  input frame_end, input body_length, input status, output ready);
endinterface

// File: hdl/clsf_apb_regs.sv
`timescale 1ns / 1ps
// APB configuration registers: header size limit and body length limit.
// Uses clsf_pkg.
module clsf_apb_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output clsf_pkg::clsf_cfg_t cfg
);
    import clsf_pkg::*;

    logic [HDR_W-1:0]  max_header_reg;
    logic [BODY_W-1:0] max_body_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_header_reg <= MAX_HEADER_RESET;
            max_body_reg   <= MAX_BODY_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_MAX_HEADER: max_header_reg <= pwdata[HDR_W-1:0];
                REG_MAX_BODY:   max_body_reg   <= pwdata[BODY_W-1:0];
                default:        max_header_reg <= max_header_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MAX_HEADER: prdata = {{(32-HDR_W){1'b0}}, max_header_reg};
            REG_MAX_BODY:   prdata = {{(32-BODY_W){1'b0}}, max_body_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg.max_header_bytes = max_header_reg;
    assign cfg.max_body_bytes   = max_body_reg;

endmodule

// File: hdl/clsf_core.sv
`timescale 1ns / 1ps
// Framing state and the per-byte header scanner, terminator match and body count.
// Uses clsf_pkg; fed one byte per step from the top level's input register.
module clsf_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             data_byte,
    input  logic                   new_stream,
    input  clsf_pkg::clsf_cfg_t    cfg,
    output clsf_pkg::clsf_result_t result
);
    import clsf_pkg::*;

    logic              phase_reg,     phase_next;
    logic [1:0]        tmatch_reg,    tmatch_next;
    logic [HDR_W-1:0]  hcount_reg,    hcount_next;
    logic [3:0]        kpos_reg,      kpos_next;
    logic [2:0]        lfs_reg,       lfs_next;
    logic [ACC_W-1:0]  accum_reg,     accum_next;
    logic              found_reg,     found_next;
    logic [BODY_W-1:0] remain_reg,    remain_next;
    logic [1:0]        err_reg,       err_next;

    // State as seen by this byte, after an optional stream restart
    logic              phase_cur;
    logic [1:0]        tmatch_cur;
    logic [HDR_W-1:0]  hcount_cur;
    logic [3:0]        kpos_cur;
    logic [2:0]        lfs_cur;
    logic [ACC_W-1:0]  accum_cur;
    logic              found_cur;
    logic [BODY_W-1:0] remain_cur;
    logic [1:0]        err_cur;

    logic              digit, blank, prev_cr, done, eol, bad_len;
    logic [7:0]        folded;
    logic [HDR_W-1:0]  hcount_inc;
    logic [BODY_W-1:0] remain_dec;
    logic [ACC_W-1:0]  acc_more, acc_first;
    logic [ACC_W-1:0]  len;

    assign phase_cur  = new_stream ? 1'b0 : phase_reg;
    assign tmatch_cur = new_stream ? TM_NONE : tmatch_reg;
    assign hcount_cur = new_stream ? '0 : hcount_reg;
    assign kpos_cur   = new_stream ? 4'd0 : kpos_reg;
    assign lfs_cur    = new_stream ? LF_KEY_LEAD : lfs_reg;
    assign accum_cur  = new_stream ? '0 : accum_reg;
    assign found_cur  = new_stream ? 1'b0 : found_reg;
    assign remain_cur = new_stream ? '0 : remain_reg;
    assign err_cur    = new_stream ? ST_OK : err_reg;

    assign digit      = (data_byte >= 8'h30) && (data_byte <= 8'h39);
    assign blank      = is_blank(data_byte);
    assign folded     = fold_case(data_byte);
    assign prev_cr    = (tmatch_cur == TM_CR) || (tmatch_cur == TM_CR2);
    assign done       = (tmatch_cur == TM_CR2) && (data_byte == CH_LF);
    assign eol        = (data_byte == CH_LF) && prev_cr;
    assign hcount_inc = (hcount_cur < COUNT_MAX) ? (hcount_cur + 16'd1) : hcount_cur;
    assign remain_dec = (remain_cur != '0) ? (remain_cur - 22'd1) : remain_cur;
    assign acc_more   = add_digit(accum_cur, data_byte[3:0]);
    assign acc_first  = {{(ACC_W-4){1'b0}}, data_byte[3:0]};

    always_comb
    begin
        phase_next  = phase_cur;
        tmatch_next = tmatch_cur;
        hcount_next = hcount_cur;
        kpos_next   = kpos_cur;
        lfs_next    = lfs_cur;
        accum_next  = accum_cur;
        found_next  = found_cur;
        remain_next = remain_cur;
        err_next    = err_cur;
        bad_len     = 1'b0;
        len         = '0;

        result.out_byte    = data_byte;
        result.in_body     = 1'b0;
        result.hdr_done    = 1'b0;
        result.frame_end   = 1'b0;
        result.body_length = '0;
        result.status      = err_cur;

        if (err_cur != ST_OK)
        begin
            // sticky error: echo only
        end
        else if (phase_cur)
        begin
            result.in_body = 1'b1;
            remain_next    = remain_dec;
            if (remain_dec == '0)
            begin
                result.frame_end = 1'b1;
                phase_next       = 1'b0;
                tmatch_next      = TM_NONE;
                hcount_next      = '0;
                kpos_next        = 4'd0;
                lfs_next         = LF_KEY_LEAD;
                accum_next       = '0;
                found_next       = 1'b0;
            end
        end
        else if (!done && (hcount_cur >= cfg.max_header_bytes))
        begin
            err_next      = ST_HDR_LONG;
            result.status = ST_HDR_LONG;
        end
        else
        begin
            hcount_next = hcount_inc;

            if (data_byte == CH_CR)
                tmatch_next = (tmatch_cur == TM_CRLF) ? TM_CR2 : TM_CR;
            else if (eol)
                tmatch_next = (tmatch_cur == TM_CR) ? TM_CRLF : TM_NONE;
            else
                tmatch_next = TM_NONE;

            if (!found_cur)
            begin
                if (eol)
                begin
                    if (hcount_inc == 16'd2)
                    begin
                        // header opens with an empty line: no length
                        found_next = 1'b1;
                        accum_next = '0;
                    end
                    else if ((lfs_cur == LF_VAL_LEAD) || (lfs_cur == LF_SIGN))
                        bad_len = 1'b1;
                    else if (lfs_cur == LF_DIGITS)
                        found_next = 1'b1;
                    else
                    begin
                        lfs_next  = LF_KEY_LEAD;
                        kpos_next = 4'd0;
                    end
                end
                else
                begin
                    case (lfs_cur)
                        LF_KEY_LEAD:
                        begin
                            if (!blank)
                            begin
                                if (folded == key_char(4'd0))
                                begin
                                    kpos_next = 4'd1;
                                    lfs_next  = LF_KEY;
                                end
                                else
                                    lfs_next = LF_SKIP;
                            end
                        end
                        LF_KEY:
                        begin
                            if (data_byte == CH_COLON)
                                lfs_next = (kpos_cur == KEY_LEN) ? LF_VAL_LEAD : LF_SKIP;
                            else if (blank)
                                lfs_next = (kpos_cur == KEY_LEN) ? LF_KEY_TRAIL : LF_SKIP;
                            else if ((kpos_cur < KEY_LEN) && (folded == key_char(kpos_cur)))
                                kpos_next = kpos_cur + 4'd1;
                            else
                                lfs_next = LF_SKIP;
                        end
                        LF_KEY_TRAIL:
                        begin
                            if (!blank)
                                lfs_next = (data_byte == CH_COLON) ? LF_VAL_LEAD : LF_SKIP;
                        end
                        LF_VAL_LEAD:
                        begin
                            if (!blank)
                            begin
                                if (data_byte == CH_PLUS)
                                    lfs_next = LF_SIGN;
                                else if (digit)
                                begin
                                    accum_next = acc_first;
                                    lfs_next   = LF_DIGITS;
                                end
                                else
                                    bad_len = 1'b1;
                            end
                        end
                        LF_SIGN:
                        begin
                            if (digit)
                            begin
                                accum_next = acc_first;
                                lfs_next   = LF_DIGITS;
                            end
                            else
                                bad_len = 1'b1;
                        end
                        LF_DIGITS:
                        begin
                            if (digit)
                                accum_next = acc_more;
                            else
                            begin
                                found_next = 1'b1;
                                lfs_next   = LF_SKIP;
                            end
                        end
                        default:
                        begin
                            lfs_next = lfs_cur;
                        end
                    endcase
                end
            end

            if (bad_len)
            begin
                err_next      = ST_BAD_LENGTH;
                result.status = ST_BAD_LENGTH;
            end
            else if (done)
            begin
                len = found_next ? accum_next : '0;
                if (len > {1'b0, cfg.max_body_bytes})
                begin
                    err_next      = ST_BODY_LONG;
                    result.status = ST_BODY_LONG;
                end
                else
                begin
                    result.hdr_done    = 1'b1;
                    result.body_length = len[BODY_W-1:0];
                    result.frame_end   = (len == '0);
                    phase_next         = (len != '0);
                    remain_next        = len[BODY_W-1:0];
                    tmatch_next        = TM_NONE;
                    hcount_next        = '0;
                    kpos_next          = 4'd0;
                    lfs_next           = LF_KEY_LEAD;
                    accum_next         = '0;
                    found_next         = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= 1'b0;
            tmatch_reg <= TM_NONE;
            hcount_reg <= '0;
            kpos_reg   <= 4'd0;
            lfs_reg    <= LF_KEY_LEAD;
            accum_reg  <= '0;
            found_reg  <= 1'b0;
            remain_reg <= '0;
            err_reg    <= ST_OK;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            tmatch_reg <= tmatch_next;
            hcount_reg <= hcount_next;
            kpos_reg   <= kpos_next;
            lfs_reg    <= lfs_next;
            accum_reg  <= accum_next;
            found_reg  <= found_next;
            remain_reg <= remain_next;
            err_reg    <= err_next;
        end
    end

endmodule

// File: hdl/content_length_stream_framer_unit.sv
`timescale 1ns / 1ps
// Content-length stream framer: input word register, one-pass scanner, result register.
// A word accepted into the input register has its result registered and offered at the
// output once the result slot is free. Throughput: one byte per cycle while the output
// is not stalled, set by the single pass of the scanner over the input register into the
// framing state. Reset (rst_n low, asynchronous) empties both registers, clears all
// framing state and errors, and loads the limit defaults.
module content_length_stream_framer_unit (
    input  logic        clk,
    input  logic        rst_n,
    clsf_in_if.sink     byte_in,
    clsf_out_if.source  byte_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import clsf_pkg::*;

    clsf_cfg_t    cfg;
    clsf_result_t core_result;

    logic         s1_valid_reg, s1_valid_next;
    logic [7:0]   s1_byte_reg;
    logic         s1_new_reg;
    logic         out_valid_reg, out_valid_next;
    clsf_result_t out_reg;

    logic         out_free, advance, accept;

    clsf_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    clsf_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .data_byte  (s1_byte_reg),
        .new_stream (s1_new_reg),
        .cfg        (cfg),
        .result     (core_result)
    );

    assign out_free      = !out_valid_reg || byte_out.ready;
    assign advance       = s1_valid_reg && out_free;
    assign byte_in.ready = !s1_valid_reg || out_free;
    assign accept        = byte_in.valid && byte_in.ready;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (byte_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: hold until the stage moves
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= byte_in.data_byte;
            s1_new_reg  <= byte_in.new_stream;
        end
        if (advance)
            out_reg <= core_result;
    end

    assign byte_out.valid       = out_valid_reg;
    assign byte_out.out_byte    = out_reg.out_byte;
    assign byte_out.in_body     = out_reg.in_body;
    assign byte_out.hdr_done    = out_reg.hdr_done;
    assign byte_out.frame_end   = out_reg.frame_end;
    assign byte_out.body_length = out_reg.body_length;
    assign byte_out.status      = out_reg.status;

`ifndef SYNTHESIS
    a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_out.valid && (byte_out.status != ST_OK)) |->
        (!byte_out.in_body && !byte_out.hdr_done && !byte_out.frame_end &&
         (byte_out.body_length == '0)))
        else $error("flags set on an errored word");

    a_len_at_hdr_end: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_out.valid && !byte_out.hdr_done) |-> (byte_out.body_length == '0))
        else $error("body length outside header end");

    a_frame_end_src: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_out.valid && byte_out.frame_end) |->
        (byte_out.in_body || (byte_out.hdr_done && (byte_out.body_length == '0))))
        else $error("frame end with no body byte and no empty header end");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_in.ready |-> (s1_valid_reg && out_valid_reg && !byte_out.ready))
        else $error("input stalled without a full pipeline");
`endif

endmodule

// File: test/clsf_frame_check.sv
`timescale 1ns / 1ps
// Framing checker: watches the byte and result channels and the register port,
// predicts each result word and compares it. Depends on clsf_pkg and the stream interfaces.
module clsf_frame_check (
    input  logic        clk,
    input  logic        rst_n,
    clsf_in_if          byte_in,
    clsf_out_if         byte_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          words_outstanding
);
    import clsf_pkg::*;

    localparam logic [8*14-1:0] KEY_STR = "content-length";

    // limits as last written
    logic [HDR_W-1:0]  hdr_limit;
    logic [BODY_W-1:0] body_limit;

    // framing state
    logic              in_body_phase;
    logic [1:0]        term_seen;
    logic [HDR_W-1:0]  hdr_bytes;
    logic [3:0]        key_pos;
    logic [2:0]        scan_st;
    logic [ACC_W-1:0]  len_acc;
    logic              len_done;
    logic [BODY_W-1:0] body_left;
    logic [1:0]        err;

    clsf_result_t expected_q[$];
    clsf_result_t predicted;

    function automatic logic space_like(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic [7:0] lower(input logic [7:0] c);
        if ((c >= "A") && (c <= "Z"))
            return c + 8'h20;
        return c;
    endfunction

    function automatic logic [7:0] key_at(input logic [3:0] pos);
        if (pos < KEY_LEN)
            return KEY_STR[8*(int'(KEY_LEN) - 1 - int'(pos)) +: 8];
        return 8'h00;
    endfunction

    function automatic logic [ACC_W-1:0] push_digit(input logic [ACC_W-1:0] acc,
                                                    input logic [7:0] c);
        logic [ACC_W+3:0] v;
        v = ({4'b0000, acc} * 27'd10) + {19'd0, (c - 8'h30)};
        return (v > {4'b0000, ACCUM_MAX}) ? ACCUM_MAX : v[ACC_W-1:0];
    endfunction

    task automatic clear_framing();
        in_body_phase = 1'b0;
        term_seen     = TM_NONE;
        hdr_bytes     = '0;
        key_pos       = '0;
        scan_st       = LF_KEY_LEAD;
        len_acc       = '0;
        len_done      = 1'b0;
        body_left     = '0;
    endtask

    // Line scanner for a header byte that does not end a line
    task automatic scan_header_char(input logic [7:0] c);
        logic digit;
        digit = (c >= "0") && (c <= "9");
        case (scan_st)
            LF_KEY_LEAD:
                if (!space_like(c))
                begin
                    if (lower(c) == key_at(4'd0))
                    begin
                        key_pos = 4'd1;
                        scan_st = LF_KEY;
                    end
                    else
                        scan_st = LF_SKIP;
                end
            LF_KEY:
                if (c == CH_COLON)
                    scan_st = (key_pos == KEY_LEN) ? LF_VAL_LEAD : LF_SKIP;
                else if (space_like(c))
                    scan_st = (key_pos == KEY_LEN) ? LF_KEY_TRAIL : LF_SKIP;
                else if ((key_pos < KEY_LEN) && (lower(c) == key_at(key_pos)))
                    key_pos = key_pos + 4'd1;
                else
                    scan_st = LF_SKIP;
            LF_KEY_TRAIL:
                if (!space_like(c))
                    scan_st = (c == CH_COLON) ? LF_VAL_LEAD : LF_SKIP;
            LF_VAL_LEAD:
                if (!space_like(c))
                begin
                    if (c == CH_PLUS)
                        scan_st = LF_SIGN;
                    else if (digit)
                    begin
                        len_acc = push_digit('0, c);
                        scan_st = LF_DIGITS;
                    end
                    else
                        err = ST_BAD_LENGTH;
                end
            LF_SIGN:
                if (digit)
                begin
                    len_acc = push_digit('0, c);
                    scan_st = LF_DIGITS;
                end
                else
                    err = ST_BAD_LENGTH;
            LF_DIGITS:
                if (digit)
                    len_acc = push_digit(len_acc, c);
                else
                begin
                    len_done = 1'b1;
                    scan_st  = LF_SKIP;
                end
            default: ;
        endcase
    endtask

    task automatic frame_byte(input logic [7:0] b, input logic fresh, output clsf_result_t r);
        logic             prev_cr;
        logic             done;
        logic [ACC_W-1:0] len;
        if (fresh)
        begin
            clear_framing();
            err = ST_OK;
        end
        r          = '0;
        r.out_byte = b;
        if (err != ST_OK)
        begin
            r.status = err;
            return;
        end
        if (in_body_phase)
        begin
            r.in_body = 1'b1;
            if (body_left != 0)
                body_left = body_left - 1'b1;
            if (body_left == 0)
            begin
                r.frame_end = 1'b1;
                clear_framing();
            end
            return;
        end

        prev_cr = (term_seen == TM_CR) || (term_seen == TM_CR2);
        done    = (term_seen == TM_CR2) && (b == CH_LF);
        if (!done && (hdr_bytes >= hdr_limit))
        begin
            err      = ST_HDR_LONG;
            r.status = err;
            return;
        end
        if (hdr_bytes != COUNT_MAX)
            hdr_bytes = hdr_bytes + 1'b1;

        if (b == CH_CR)
            term_seen = (term_seen == TM_CRLF) ? TM_CR2 : TM_CR;
        else if ((b == CH_LF) && prev_cr)
            term_seen = (term_seen == TM_CR) ? TM_CRLF : TM_NONE;
        else
            term_seen = TM_NONE;

        if (!len_done)
        begin
            if ((b == CH_LF) && prev_cr)
            begin
                // header opening with CR LF: stop scanning, no body
                if (hdr_bytes == 2)
                begin
                    len_done = 1'b1;
                    len_acc  = '0;
                end
                else if ((scan_st == LF_VAL_LEAD) || (scan_st == LF_SIGN))
                    err = ST_BAD_LENGTH;
                else if (scan_st == LF_DIGITS)
                    len_done = 1'b1;
                else
                begin
                    scan_st = LF_KEY_LEAD;
                    key_pos = '0;
                end
            end
            else
                scan_header_char(b);
        end

        if (err != ST_OK)
        begin
            r.status = err;
            return;
        end

        if (done)
        begin
            len = len_done ? len_acc : '0;
            if (len > body_limit)
            begin
                err      = ST_BODY_LONG;
                r.status = err;
                return;
            end
            r.hdr_done    = 1'b1;
            r.body_length = len[BODY_W-1:0];
            clear_framing();
            if (len == 0)
                r.frame_end = 1'b1;
            else
            begin
                in_body_phase = 1'b1;
                body_left     = len[BODY_W-1:0];
            end
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        fail_count++;
        // keep the log readable when the block is badly off
        if (fail_count <= 60)
            $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task automatic compare_word();
        clsf_result_t want;
        if (expected_q.size() == 0)
        begin
            report("word with nothing expected", 32'(byte_out.out_byte), 32'h0);
            return;
        end
        want = expected_q.pop_front();
        if (byte_out.out_byte !== want.out_byte)
            report("out_byte", 32'(byte_out.out_byte), 32'(want.out_byte));
        if (byte_out.in_body !== want.in_body)
            report("in_body", 32'(byte_out.in_body), 32'(want.in_body));
        if (byte_out.hdr_done !== want.hdr_done)
            report("hdr_done", 32'(byte_out.hdr_done), 32'(want.hdr_done));
        if (byte_out.frame_end !== want.frame_end)
            report("frame_end", 32'(byte_out.frame_end), 32'(want.frame_end));
        if (byte_out.body_length !== want.body_length)
            report("body_length", 32'(byte_out.body_length), 32'(want.body_length));
        if (byte_out.status !== want.status)
            report("status", 32'(byte_out.status), 32'(want.status));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_limit  = MAX_HEADER_RESET;
            body_limit = MAX_BODY_RESET;
            err        = ST_OK;
            clear_framing();
            expected_q.delete();
            words_outstanding = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_MAX_HEADER)
                    hdr_limit = pwdata[HDR_W-1:0];
                else
                    body_limit = pwdata[BODY_W-1:0];
            end
            if (byte_out.valid && byte_out.ready)
                compare_word();
            if (byte_in.valid && byte_in.ready)
            begin
                frame_byte(byte_in.data_byte, byte_in.new_stream, predicted);
                expected_q.insert(expected_q.size(), predicted);
            end
            words_outstanding = expected_q.size();
        end
    end

endmodule

// File: test/tb_content_length_stream_framer_unit.sv
`timescale 1ns / 1ps
// Testbench top: builds SIP-like byte streams, drives the framer and its limit registers,
// and gives the verdict. Depends on clsf_pkg, the stream interfaces and clsf_frame_check.
module tb_content_length_stream_framer_unit;
    import clsf_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    typedef enum int {
        MSG_GOOD,
        MSG_NO_KEY,
        MSG_EMPTY,
        MSG_BAD_VALUE,
        MSG_BIG,
        MSG_NEAR_KEY,
        MSG_NOISE
    } msg_kind_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int sender_idle_pct;
    int receiver_stall_pct;
    int fails;
    int outstanding;
    int quiet_cycles = 0;
    int bytes_sent = 0;
    int msg_no = 0;
    int cur_body_limit;
    logic next_fresh;

    logic [7:0] msg_bytes[$];

    clsf_in_if  in_ch();
    clsf_out_if out_ch();

    content_length_stream_framer_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (in_ch),
        .byte_out (out_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    clsf_frame_check framing_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .byte_in           (in_ch),
        .byte_out          (out_ch),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .pready            (pready),
        .fail_count        (fails),
        .words_outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fresh);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.new_stream <= fresh;
        do @(posedge clk); while (!in_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_message(input logic fresh);
        for (int i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], fresh && (i == 0));
    endtask

    // drop valid and wait until every result word is back
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_limits(input int hdr, input int body);
        drain();
        write_reg(REG_MAX_HEADER, 32'(hdr));
        write_reg(REG_MAX_BODY, 32'(body));
        cur_body_limit = body;
    endtask

    task automatic put_byte(input logic [7:0] c);
        msg_bytes.insert(msg_bytes.size(), c);
    endtask

    task automatic drop_last();
        msg_bytes.delete(msg_bytes.size() - 1);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task automatic put_mixed_case(input string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if ((c >= "a") && (c <= "z") && ($urandom_range(1) == 1))
                c = c - 8'h20;
            put_byte(c);
        end
    endtask

    task automatic put_crlf();
        put_byte(CH_CR);
        put_byte(CH_LF);
    endtask

    // blanks of every kind, never a CR directly followed by LF
    task automatic put_blanks(input int n);
        logic [7:0] c;
        logic [7:0] last;
        last = (msg_bytes.size() != 0) ? msg_bytes[$] : 8'h00;
        repeat (n)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: c = 8'h20;
                5, 6:          c = 8'h09;
                7:             c = ($urandom_range(1) == 1) ? 8'h0B : 8'h0C;
                8:             c = CH_CR;
                default:       c = CH_LF;
            endcase
            if ((c == CH_LF) && (last == CH_CR))
                c = 8'h20;
            put_byte(c);
            last = c;
        end
    endtask

    task automatic put_junk_line(input logic request);
        if (request)
            put_text("INVITE sip:bob@host SIP/2.0");
        else
            case ($urandom_range(4))
                0: put_mixed_case("via: sip/2.0/tcp h1");
                1: put_mixed_case("cseq: 7 invite");
                2: put_mixed_case("content-type: app/sdp");
                3: put_mixed_case("contact: <sip:a@b>");
                default:
                    repeat ($urandom_range(1, 10))
                        put_byte(8'($urandom_range(8'h0E, 8'hFF)));
            endcase
        put_crlf();
    endtask

    task automatic put_key_line(input string value);
        if ($urandom_range(3) == 0)
            put_blanks($urandom_range(1, 2));
        put_mixed_case("content-length");
        if ($urandom_range(3) == 0)
            put_blanks($urandom_range(1, 2));
        put_byte(CH_COLON);
        if ($urandom_range(1) == 1)
            put_blanks($urandom_range(1, 2));
        put_text(value);
        put_crlf();
    endtask

    function automatic string length_text(input int n);
        string s;
        s = "";
        if ($urandom_range(2) == 0)
            s = "+";
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 2)) s = {s, "0"};
        s = {s, $sformatf("%0d", n)};
        case ($urandom_range(3))
            1:       s = {s, " "};
            2:       s = {s, ";tag=x"};
            default: ;
        endcase
        return s;
    endfunction

    function automatic string big_digits();
        string s;
        s = $sformatf("%0d", $urandom_range(1, 9));
        repeat ($urandom_range(7, 11))
            s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        return s;
    endfunction

    function automatic int pick_length();
        int n;
        n = $urandom_range(0, 12);
        if ($urandom_range(9) == 0)
            n = $urandom_range(13, 40);
        return (n > cur_body_limit) ? cur_body_limit : n;
    endfunction

    task automatic compose_message(input msg_kind_t kind);
        int body_bytes;
        int cut;
        msg_bytes.delete();
        body_bytes = 0;
        case (kind)
            MSG_GOOD:
            begin
                if ($urandom_range(9) < 7)
                    put_junk_line(1'b1);
                repeat ($urandom_range(0, 2)) put_junk_line(1'b0);
                body_bytes = pick_length();
                put_key_line(length_text(body_bytes));
                // a later key line is ignored
                if ($urandom_range(3) == 0)
                    put_key_line(length_text($urandom_range(0, 99)));
                repeat ($urandom_range(0, 1)) put_junk_line(1'b0);
                put_crlf();
            end
            MSG_NO_KEY:
            begin
                repeat ($urandom_range(1, 3)) put_junk_line($urandom_range(1) == 1);
                put_crlf();
            end
            MSG_EMPTY:
            begin
                put_crlf();
                if ($urandom_range(1) == 1)
                    put_key_line(length_text($urandom_range(1, 9)));
                put_crlf();
            end
            MSG_BAD_VALUE:
            begin
                if ($urandom_range(1) == 1)
                    put_junk_line(1'b1);
                case ($urandom_range(5))
                    0: put_key_line("");
                    1: put_key_line("-5");
                    2: put_key_line("+");
                    3: put_key_line("+x7");
                    4: put_key_line("abc");
                    default: put_key_line(" ");
                endcase
                put_crlf();
            end
            MSG_BIG:
            begin
                if ($urandom_range(1) == 1)
                    put_key_line(big_digits());
                else
                    put_key_line($sformatf("%0d", cur_body_limit + $urandom_range(1, 3)));
                put_crlf();
            end
            MSG_NEAR_KEY:
            begin
                case ($urandom_range(5))
                    0: put_mixed_case("content-lengthx: 4");
                    1: put_mixed_case("content length: 4");
                    2: put_mixed_case("contentlength: 4");
                    3: put_mixed_case("content-lengt: 4");
                    4: put_mixed_case("content-length 4");
                    default: put_mixed_case("xcontent-length: 4");
                endcase
                put_crlf();
                if ($urandom_range(1) == 1)
                begin
                    body_bytes = pick_length();
                    put_key_line(length_text(body_bytes));
                end
                put_crlf();
            end
            default:
                repeat ($urandom_range(4, 24))
                    case ($urandom_range(9))
                        0, 1:    put_byte(CH_CR);
                        2:       put_byte(CH_LF);
                        default: put_byte(8'($urandom_range(0, 255)));
                    endcase
        endcase
        repeat (body_bytes)
            put_byte(8'($urandom_range(0, 255)));
        // cut some messages short, the next one then opens a new stream
        if ((msg_bytes.size() > 2) && ($urandom_range(99) < 8))
        begin
            cut = $urandom_range(1, msg_bytes.size() - 1);
            while (msg_bytes.size() > cut)
                drop_last();
            next_fresh = 1'b1;
        end
    endtask

    task automatic run_phase(input int hdr, input int body, input int n_bytes);
        int target;
        int pick;
        msg_kind_t kind;
        logic fresh;
        set_limits(hdr, body);
        target     = bytes_sent + n_bytes;
        next_fresh = 1'b1;
        while (bytes_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 50)      kind = MSG_GOOD;
            else if (pick < 58) kind = MSG_NO_KEY;
            else if (pick < 65) kind = MSG_EMPTY;
            else if (pick < 74) kind = MSG_BAD_VALUE;
            else if (pick < 82) kind = MSG_BIG;
            else if (pick < 92) kind = MSG_NEAR_KEY;
            else                kind = MSG_NOISE;
            fresh      = next_fresh || ($urandom_range(4) == 0);
            next_fresh = (kind == MSG_BAD_VALUE) || (kind == MSG_BIG) || (kind == MSG_NOISE) ||
                         ((hdr < 100) && ($urandom_range(1) == 1));
            compose_message(kind);
            // stop the phase at its byte budget
            if (msg_bytes.size() > (target - bytes_sent))
            begin
                while (msg_bytes.size() > (target - bytes_sent))
                    drop_last();
                next_fresh = 1'b1;
            end
            case ((msg_no / 3) % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 65; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 65; end
                default: begin sender_idle_pct = 22; receiver_stall_pct = 22; end
            endcase
            msg_no++;
            send_message(fresh);
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_ch.valid        = 1'b0;
        in_ch.data_byte    = '0;
        in_ch.new_stream   = 1'b0;
        out_ch.ready       = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        cur_body_limit     = int'(MAX_BODY_RESET);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // header made of an empty first line, then a message with a short body of extreme bytes
        msg_bytes.delete();
        put_crlf();
        put_crlf();
        send_message(1'b1);
        msg_bytes.delete();
        put_text("Content-Length: +2");
        put_crlf();
        put_crlf();
        put_byte(8'h00);
        put_byte(8'hFF);
        send_message(1'b0);

        // no header room at all: the very first byte is flagged as an over-long header
        set_limits(0, int'(MAX_BODY_RESET));
        msg_bytes.delete();
        put_text("ab");
        put_byte(CH_CR);
        send_message(1'b1);

        run_phase(int'(MAX_HEADER_RESET), int'(MAX_BODY_RESET), 90);
        run_phase(40, 8, 100);
        run_phase(65535, 4194303, 100);
        run_phase(1, 0, 40);
        run_phase($urandom_range(24, 200), $urandom_range(0, 30), 100);

        drain();
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
